FILE: sv/char_class_run_repeat_stats_unit_defines.svh
// Assertion macros shared by the checker of the character class statistics unit.
// Each macro samples on clock and is disabled while reset is high.
`ifndef CHAR_CLASS_RUN_REPEAT_STATS_UNIT_DEFINES_SVH
`define CHAR_CLASS_RUN_REPEAT_STATS_UNIT_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define CCRS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define CCRS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Consequent holds after a delay from the antecedent.
`define CCRS_ASSERT_LATER(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##2 (cons)) \
      else $error(msg);

`endif

FILE: sv/ccrs_pkg.sv
// Types, constants and the byte classifier of the character class statistics unit.
// Used by the top level and its checker; depends on nothing.
`default_nettype none

package ccrs_pkg;

   localparam int CH_BITS       = 8;
   localparam int FIELD_BITS    = 16;
   localparam int WIDE_BITS     = 32;
   localparam int NUM_CLASSES   = 4;
   localparam int NUM_COUNTS    = 3 * NUM_CLASSES;
   localparam int RSP_DATA_BITS = NUM_COUNTS * FIELD_BITS;
   localparam int MAP_DEPTH     = 1 << CH_BITS;
   localparam int EPOCH_BITS    = 4;

   // Offsets of the three counter groups in the counter array.
   localparam int GRP_TOTAL = 0;
   localparam int GRP_RUN   = NUM_CLASSES;
   localparam int GRP_REP   = 2 * NUM_CLASSES;

   typedef enum logic [2:0] {
      CLS_DIGIT = 3'd0,
      CLS_LOWER = 3'd1,
      CLS_UPPER = 3'd2,
      CLS_SIGN  = 3'd3,
      CLS_NONE  = 3'd4
   } class_type;

   function automatic class_type classify(input logic [CH_BITS-1:0] c);
      class_type cls;
      if (c >= "0" && c <= "9") begin
         cls = CLS_DIGIT;
      end else if (c >= "a" && c <= "z") begin
         cls = CLS_LOWER;
      end else if (c >= "A" && c <= "Z") begin
         cls = CLS_UPPER;
      end else begin
         cls = CLS_SIGN;
      end
      return cls;
   endfunction

endpackage

`default_nettype wire

FILE: sv/char_class_run_repeat_stats_unit.sv
// A request passes the s1 stage register and the result register to rsp_tvalid.
// Throughput: one request per cycle while the result channel is free; the seen-map
// RAM read-modify-write forwards the last written byte past its registered read.
// Synchronous reset clears counters, previous class, epoch and the map valid bits at
// once; no clearing pass. A start request bumps the epoch tag instead of clearing.
`default_nettype none

module char_class_run_repeat_stats_unit #(
   parameter int COUNT_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [ccrs_pkg::CH_BITS-1:0]        req_tdata,  // [7:0] ch
   input  wire logic                                req_tuser,  // [0] start_req
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [15:0] count_digit, count_lower, count_upper, count_sign,
   // run_digit, run_lower, run_upper, run_sign,
   // rep_digit, rep_lower, rep_upper, [191:176] rep_sign
   output logic      [ccrs_pkg::RSP_DATA_BITS-1:0]  rsp_tdata
);

   import ccrs_pkg::*;

   logic                  req_accept;
   logic                  s1_fire;

   logic                  s1_valid_ff;
   logic [CH_BITS-1:0]    s1_ch_ff;
   logic                  s1_start_ff;

   logic [EPOCH_BITS-1:0] epoch_ff;
   logic [EPOCH_BITS-1:0] epoch_in;
   logic [EPOCH_BITS-1:0] tag_rd;
   logic                  epoch_wrap;

   logic [MAP_DEPTH-1:0]  map_valid_ff;
   logic [MAP_DEPTH-1:0]  map_valid_in;
   logic [CH_BITS-1:0]    last_wr_addr_ff;
   logic                  last_wr_vld_ff;
   logic                  fwd_hit;
   logic                  seen;

   class_type             prev_ff;
   class_type             prev_base;
   class_type             cls;
   logic [1:0]            cls_idx;
   logic                  run_hit;

   logic [COUNT_BITS-1:0] cnt_ff [NUM_COUNTS];
   logic [COUNT_BITS-1:0] cnt_in [NUM_COUNTS];
   logic [COUNT_BITS-1:0] cnt_base;
   logic [NUM_COUNTS-1:0] inc;
   logic [WIDE_BITS-1:0]  cnt_wide;

   logic                     rsp_valid_ff;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff;
   logic [RSP_DATA_BITS-1:0] rsp_data_in;

   assign s1_fire    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign req_accept = req_tvalid && req_tready;

   ccrs_ram #(
      .WIDTH (EPOCH_BITS),
      .DEPTH (MAP_DEPTH)
   ) u_seen_ram (
      .clock   (clock),
      .wr_en   (s1_fire),
      .wr_addr (s1_ch_ff),
      .wr_data (epoch_in),
      .rd_en   (req_accept),
      .rd_addr (req_tdata),
      .rd_data (tag_rd)
   );

   // Seen-map lookup: entry is live when its valid bit is set and its tag matches
   // the current epoch; the previous request's write is forwarded.
   always_comb begin
      epoch_in   = s1_start_ff ? epoch_ff + 1'b1 : epoch_ff;
      epoch_wrap = s1_start_ff && (epoch_ff == '1);
      fwd_hit    = last_wr_vld_ff && (last_wr_addr_ff == s1_ch_ff);
      seen       = !s1_start_ff &&
                   (fwd_hit || (map_valid_ff[s1_ch_ff] && (tag_rd == epoch_ff)));
      map_valid_in = epoch_wrap ? '0 : map_valid_ff;
      map_valid_in[s1_ch_ff] = 1'b1;
   end

   always_comb begin
      cls       = classify(s1_ch_ff);
      cls_idx   = cls[1:0];
      prev_base = s1_start_ff ? CLS_NONE : prev_ff;
      run_hit   = (prev_base == cls);
      for (int c = 0; c < NUM_CLASSES; c++) begin
         inc[GRP_TOTAL + c] = (cls_idx == 2'(c));
         inc[GRP_RUN + c]   = (cls_idx == 2'(c)) && run_hit;
         inc[GRP_REP + c]   = (cls_idx == 2'(c)) && seen;
      end
   end

   // Saturating update of all counters; mask each to the result field.
   always_comb begin
      cnt_base    = '0;
      cnt_wide    = '0;
      rsp_data_in = '0;
      for (int i = 0; i < NUM_COUNTS; i++) begin
         cnt_base = s1_start_ff ? '0 : cnt_ff[i];
         if (inc[i] && (cnt_base != '1)) begin
            cnt_in[i] = cnt_base + 1'b1;
         end else begin
            cnt_in[i] = cnt_base;
         end
         cnt_wide = WIDE_BITS'(cnt_in[i]);
         rsp_data_in[i*FIELD_BITS +: FIELD_BITS] = cnt_wide[FIELD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         epoch_ff       <= '0;
         map_valid_ff   <= '0;
         last_wr_vld_ff <= 1'b0;
         prev_ff        <= CLS_NONE;
         for (int i = 0; i < NUM_COUNTS; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_fire) begin
            rsp_valid_ff   <= 1'b1;
            epoch_ff       <= epoch_in;
            map_valid_ff   <= map_valid_in;
            last_wr_vld_ff <= 1'b1;
            prev_ff        <= cls;
            for (int i = 0; i < NUM_COUNTS; i++) begin
               cnt_ff[i] <= cnt_in[i];
            end
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers; hold while stalled.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ch_ff    <= req_tdata;
         s1_start_ff <= req_tuser;
      end
      if (s1_fire) begin
         rsp_data_ff     <= rsp_data_in;
         last_wr_addr_ff <= s1_ch_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: sv/ccrs_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package needed.
`default_nettype none

module ccrs_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 256,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: sv/ccrs_checker.sv
// Port-level checker for the character class statistics unit, bound to its top level.
// Depends on ccrs_pkg and the assertion macros header.
`default_nettype none
`include "char_class_run_repeat_stats_unit_defines.svh"

module ccrs_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_tvalid,
   input wire logic                                req_tready,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [ccrs_pkg::RSP_DATA_BITS-1:0]  rsp_tdata
);

   import ccrs_pkg::*;

   logic       in_acc;
   logic       out_acc;
   logic [1:0] pend_ff;
   logic [1:0] pend_in;

   assign in_acc  = req_tvalid && req_tready;
   assign out_acc = rsp_tvalid && rsp_tready;

   // Track requests accepted but not yet delivered.
   always_comb begin
      case ({in_acc, out_acc})
         2'b10:   pend_in = pend_ff + 2'd1;
         2'b01:   pend_in = pend_ff - 2'd1;
         default: pend_in = pend_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   `CCRS_ASSERT_NEXT(a_stall_hold, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")
   `CCRS_ASSERT_SAME(a_pend_bound, 1'b1, pend_ff != 2'd3, "more than two requests in flight")
   `CCRS_ASSERT_SAME(a_no_phantom, rsp_tvalid, pend_ff != 2'd0, "result without a request")
   `CCRS_ASSERT_SAME(a_ready_free, !rsp_tvalid, req_tready, "not ready with output empty")
   `CCRS_ASSERT_LATER(a_latency, in_acc, rsp_tvalid, "no result two cycles after request")

endmodule

bind char_class_run_repeat_stats_unit ccrs_checker u_ccrs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

FILE: verif/tb.sv
// Self-checking bench for char_class_run_repeat_stats_unit: byte strings go in on the request
// stream and every result is compared with a local prediction. Depends on ccrs_pkg.
// The unit is built with 8-bit counters so that the counts saturate at 255 within the long strings.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ccrs_pkg::*;

   localparam int CNT_BITS = 8;
   localparam longint unsigned CNT_MAX = (64'd1 << CNT_BITS) - 1;
   localparam int RANDOM_REQUESTS = 1500;

   typedef logic [NUM_COUNTS-1:0][FIELD_BITS-1:0] counts_type;

   typedef struct {
      logic [7:0]  ch;
      logic        start;
      bit          typed;
      int unsigned want[NUM_COUNTS];
   } dir_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [CH_BITS-1:0]       req_tdata = '0;   // [7:0] ch
   logic                     req_tuser = 1'b0; // [0] start_req
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;        // 12 x 16-bit counts, count_digit lowest

   char_class_run_repeat_stats_unit #(.COUNT_BITS(CNT_BITS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Local copy of the unit state.
   bit              byte_seen[MAP_DEPTH];
   class_type       last_class;
   longint unsigned tally[NUM_COUNTS];

   counts_type pending_stats[$];
   int      mismatches = 0;
   int      accepted = 0;
   int      checked = 0;
   int      strings = 0;
   int      saturated_results = 0;
   bit      held = 1'b0;

   string field_name[NUM_COUNTS] = '{
      "count_digit", "count_lower", "count_upper", "count_sign",
      "run_digit", "run_lower", "run_upper", "run_sign",
      "rep_digit", "rep_lower", "rep_upper", "rep_sign"
   };

   // Totals, runs and repeats per class, checked after reset, at the extremes and on clears.
   dir_row_type dir_tab[25] = '{
      '{ch: "0",   start: 1'b1, typed: 1'b1, want: '{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}},
      '{ch: "9",   start: 1'b0, typed: 1'b1, want: '{2, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0}},
      '{ch: "0",   start: 1'b0, typed: 1'b1, want: '{3, 0, 0, 0, 2, 0, 0, 0, 1, 0, 0, 0}},
      '{ch: "a",   start: 1'b0, typed: 1'b1, want: '{3, 1, 0, 0, 2, 0, 0, 0, 1, 0, 0, 0}},
      '{ch: "z",   start: 1'b0, typed: 1'b0, want: '{default: 0}},
      '{ch: "A",   start: 1'b0, typed: 1'b0, want: '{default: 0}},
      '{ch: "Z",   start: 1'b0, typed: 1'b0, want: '{default: 0}},
      '{ch: "@",   start: 1'b0, typed: 1'b0, want: '{default: 0}},
      '{ch: "[",   start: 1'b0, typed: 1'b0, want: '{default: 0}},
      '{ch: 8'h60, start: 1'b0, typed: 1'b0, want: '{default: 0}},
      '{ch: "{",   start: 1'b0, typed: 1'b0, want: '{default: 0}},
      '{ch: "/",   start: 1'b0, typed: 1'b0, want: '{default: 0}},
      '{ch: ":",   start: 1'b0, typed: 1'b0, want: '{default: 0}},
      '{ch: 8'h80, start: 1'b0, typed: 1'b0, want: '{default: 0}},
      '{ch: 8'h7F, start: 1'b0, typed: 1'b0, want: '{default: 0}},
      '{ch: 8'h01, start: 1'b0, typed: 1'b0, want: '{default: 0}},
      '{ch: 8'h00, start: 1'b0, typed: 1'b0, want: '{default: 0}},
      '{ch: 8'hFF, start: 1'b1, typed: 1'b1, want: '{0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0}},
      '{ch: 8'hFF, start: 1'b0, typed: 1'b1, want: '{0, 0, 0, 2, 0, 0, 0, 1, 0, 0, 0, 1}},
      '{ch: "5",   start: 1'b1, typed: 1'b1, want: '{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}},
      '{ch: "5",   start: 1'b1, typed: 1'b1, want: '{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}},
      '{ch: "Q",   start: 1'b0, typed: 1'b1, want: '{1, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0}},
      '{ch: "q",   start: 1'b0, typed: 1'b1, want: '{1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0}},
      '{ch: "Q",   start: 1'b0, typed: 1'b1, want: '{1, 1, 2, 0, 0, 0, 0, 0, 0, 0, 1, 0}},
      '{ch: "Q",   start: 1'b0, typed: 1'b1, want: '{1, 1, 3, 0, 0, 0, 1, 0, 0, 0, 2, 0}}
   };

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("MISMATCH at %0t ns: %s", $time, msg);
   endtask

   function automatic class_type char_kind(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return CLS_DIGIT;
      if (c >= 8'h61 && c <= 8'h7A) return CLS_LOWER;
      if (c >= 8'h41 && c <= 8'h5A) return CLS_UPPER;
      return CLS_SIGN;
   endfunction

   function automatic void clear_stats();
      foreach (byte_seen[i]) byte_seen[i] = 1'b0;
      foreach (tally[i]) tally[i] = 0;
      last_class = CLS_NONE;
   endfunction

   function automatic void bump(input int idx);
      if (tally[idx] < CNT_MAX) tally[idx]++;
   endfunction

   // Advance the local state by one byte and return the twelve counts it leaves.
   function automatic counts_type stats_step(input logic [7:0] ch, input logic start);
      class_type  cls;
      bit         repeat_byte;
      bit         at_max;
      counts_type res;
      if (start) clear_stats();
      cls = char_kind(ch);
      repeat_byte = byte_seen[ch];
      byte_seen[ch] = 1'b1;
      bump(GRP_TOTAL + int'(cls));
      if (last_class == cls) bump(GRP_RUN + int'(cls));
      else last_class = cls;
      if (repeat_byte) bump(GRP_REP + int'(cls));
      at_max = 1'b0;
      foreach (tally[j]) begin
         res[j] = tally[j][FIELD_BITS-1:0];
         if (tally[j] == CNT_MAX) at_max = 1'b1;
      end
      if (at_max) saturated_results++;
      return res;
   endfunction

   // Mostly no gap, sometimes a short one, rarely a long one.
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] pick_of(input class_type k);
      logic [7:0] b;
      case (k)
         CLS_DIGIT: b = 8'h30 + 8'($urandom_range(0, 9));
         CLS_LOWER: b = 8'h61 + 8'($urandom_range(0, 25));
         CLS_UPPER: b = 8'h41 + 8'($urandom_range(0, 25));
         default: begin
            do b = 8'($urandom_range(1, 255)); while (char_kind(b) != CLS_SIGN);
         end
      endcase
      return b;
   endfunction

   function automatic class_type any_class();
      return class_type'($urandom_range(0, NUM_CLASSES - 1));
   endfunction

   task automatic send_request(input logic [7:0] ch, input logic start, input bit calm);
      int gap;
      gap = calm ? 0 : idle_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tuser  <= start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      accepted++;
   endtask

   // Modes: 0 any byte, 1 one class mostly, 2 few byte values, 3 short class runs, 4 one class.
   task automatic send_string(input int len, input int mode, input bit calm);
      class_type  k;
      logic [7:0] pool[4];
      logic [7:0] b;
      logic       st;
      int         run_left;
      k = any_class();
      foreach (pool[i]) pool[i] = 8'($urandom_range(1, 255));
      run_left = 0;
      strings++;
      for (int i = 0; i < len; i++) begin
         case (mode)
            0: b = ($urandom_range(0, 99) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
            1: b = ($urandom_range(0, 19) == 0) ? pick_of(any_class()) : pick_of(k);
            2: b = pool[$urandom_range(0, 3)];
            3: begin
               if (run_left == 0) begin
                  k = any_class();
                  run_left = $urandom_range(1, 6);
               end
               run_left--;
               b = pick_of(k);
            end
            default: b = pick_of(k);
         endcase
         // a stray start now and then cuts a string short
         st = (i == 0) || ($urandom_range(0, 99) == 0);
         send_request(b, st, calm);
         pending_stats.push_back(stats_step(b, st));
      end
   endtask

   // Result checker.
   always @(posedge clock) begin
      counts_type got;
      counts_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_stats.size() == 0) begin
            report_mismatch($sformatf("result with no request pending: %h", rsp_tdata));
         end else begin
            want = pending_stats.pop_front();
            checked++;
            for (int j = 0; j < NUM_COUNTS; j++) begin
               if (got[j] !== want[j])
                  report_mismatch($sformatf("result %0d %s: got %0d, want %0d",
                                            checked, field_name[j], got[j], want[j]));
            end
         end
      end
   end

   // Result side: random stalls, plus one long hold so the unit backs up.
   initial begin
      int on;
      int off;
      while (reset) @(posedge clock);
      forever begin
         if (!held && accepted >= 200) begin
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            held = 1'b1;
         end
         on = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
         rsp_tready <= 1'b1;
         repeat (on) @(posedge clock);
         off = idle_len();
         if (off > 0) begin
            rsp_tready <= 1'b0;
            repeat (off) @(posedge clock);
         end
      end
   end

   initial begin
      #20ms;
      $display("Timeout at %0t ns with %0d results outstanding", $time, pending_stats.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      counts_type predicted;
      counts_type want;
      int         random_start;
      int         len;
      int         mode;
      int         waited;
      clear_stats();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[i]) begin
         send_request(dir_tab[i].ch, dir_tab[i].start, 1'b0);
         predicted = stats_step(dir_tab[i].ch, dir_tab[i].start);
         if (dir_tab[i].typed) begin
            for (int j = 0; j < NUM_COUNTS; j++) want[j] = FIELD_BITS'(dir_tab[i].want[j]);
            pending_stats.push_back(want);
         end else begin
            pending_stats.push_back(predicted);
         end
      end

      // One string of a single, randomly chosen class, long enough to saturate its total and run counters.
      random_start = accepted;
      send_string(300, 4, 1'b0);
      while (accepted - random_start < RANDOM_REQUESTS) begin
         mode = $urandom_range(0, 3);
         len = ($urandom_range(0, 99) < 8) ? $urandom_range(256, 520) : $urandom_range(1, 40);
         send_string(len, mode, $urandom_range(0, 5) == 0);
      end
      req_tvalid <= 1'b0;

      waited = 0;
      while (pending_stats.size() != 0 && waited < 50000) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      if (pending_stats.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_stats.size()));

      $display("Ran %0d requests, the directed rows and then %0d random strings; %0d results",
               accepted, strings, checked);
      $display("checked, %0d of them with at least one count held at its maximum.",
               saturated_results);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+sv
sv/ccrs_pkg.sv
sv/ccrs_ram.sv
sv/char_class_run_repeat_stats_unit.sv
sv/ccrs_checker.sv
verif/tb.sv
